FILE: sv/sprite_quad_vertex_generator_unit_defines.svh
// Assertion macros used by the sprite quad vertex generator top module.
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SQV_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sqv check failed");
`define SQV_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sqv check failed");
`else
`define SQV_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define SQV_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: sv/sqv_pkg.sv
package sqv_pkg;

   localparam int POS_W    = 20;
   localparam int DIM_W    = 16;
   localparam int SRC_W    = 12;
   localparam int EDGE_W   = 13;
   localparam int ANG_W    = 16;
   localparam int COL_W    = 32;
   localparam int FLG_W    = 16;
   localparam int SLOT_W   = 5;
   localparam int TEX_W    = 17;
   localparam int FRAC_W   = 16;
   localparam int TRIG_W   = 17;
   localparam int PROD_W   = 34;
   localparam int LANES    = 4;
   localparam int DIV_STEPS = 16;
   localparam int PIPE_LAST = DIV_STEPS;

   localparam logic [15:0] SIN_A = 16'd25736;
   localparam logic [15:0] SIN_B = 16'd10512;
   localparam logic [15:0] SIN_C = 16'd1160;
   localparam logic [15:0] ONE_Q14 = 16'd16384;
   localparam logic [TEX_W-1:0] TEX_ONE = 17'h10000;

   localparam logic signed [POS_W+2:0] POS_MAX = 23'sd524287;
   localparam logic signed [POS_W+2:0] POS_MIN = -23'sd524288;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic ADDR_WIDTH_REG = 1'b0;
   localparam logic ADDR_HEIGHT_REG = 1'b1;

   typedef enum logic [1:0] {
      CORNER_TL = 2'd0,
      CORNER_TR = 2'd1,
      CORNER_BR = 2'd2,
      CORNER_BL = 2'd3
   } corner_type;

   typedef struct packed {
      logic signed [POS_W-1:0] rect_x;
      logic signed [POS_W-1:0] rect_y;
      logic [DIM_W-1:0]        rect_width;
      logic [DIM_W-1:0]        rect_height;
      logic                    rotated;
      logic signed [PROD_W-1:0] wc;
      logic signed [PROD_W-1:0] ws;
      logic signed [PROD_W-1:0] hc;
      logic signed [PROD_W-1:0] hs;
      logic [TEX_W-1:0]        u0;
      logic [TEX_W-1:0]        u1;
      logic [TEX_W-1:0]        v0;
      logic [TEX_W-1:0]        v1;
      logic [COL_W-1:0]        colour;
      logic [FLG_W-1:0]        flags;
      logic [SLOT_W-1:0]       slot;
   } quad_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/sprite_quad_vertex_generator_unit.sv
// Sprite to quad vertices. Each accepted sprite yields four vertices, top-left, top-right,
// bottom-right, bottom-left, one per cycle on the rsp channel while rsp_stall is low; the
// single-vertex result register lets the back end take a sprite off the queue only once
// the previous sprite's bottom-left vertex is loaded. Sprites enter a 17-stage front
// pipeline (16-step restoring dividers for the four texture coordinates, sine/cosine
// polynomial and offset products alongside), then a two-entry queue. Program atlas_width
// at 0x0 and atlas_height at 0x4 only while no sprite is in flight; a size of zero acts
// as one.
`include "sprite_quad_vertex_generator_unit_defines.svh"

module sprite_quad_vertex_generator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sqv_pkg::POS_W-1:0]   req_rect_x,
   input  logic [sqv_pkg::POS_W-1:0]   req_rect_y,
   input  logic [sqv_pkg::DIM_W-1:0]   req_rect_width,
   input  logic [sqv_pkg::DIM_W-1:0]   req_rect_height,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_x,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_y,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_width,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_height,
   input  logic [sqv_pkg::ANG_W-1:0]   req_angle,
   input  logic [sqv_pkg::COL_W-1:0]   req_colour,
   input  logic [sqv_pkg::FLG_W-1:0]   req_flags,
   input  logic [sqv_pkg::SLOT_W-1:0]  req_tex_slot,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sqv_pkg::POS_W-1:0]   rsp_pos_x,
   output logic [sqv_pkg::POS_W-1:0]   rsp_pos_y,
   output logic [sqv_pkg::TEX_W-1:0]   rsp_tex_u,
   output logic [sqv_pkg::TEX_W-1:0]   rsp_tex_v,
   output logic [sqv_pkg::COL_W-1:0]   rsp_vertex_colour,
   output logic [sqv_pkg::FLG_W-1:0]   rsp_vertex_flags,
   output logic [sqv_pkg::SLOT_W-1:0]  rsp_vertex_slot,
   output logic [1:0]                  rsp_corner,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import sqv_pkg::*;

   logic [EDGE_W-1:0] atlas_width_ff, atlas_height_ff;
   logic csr_write;
   logic push, pop;
   quad_type push_data, head;
   queue_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_width_ff  <= EDGE_W'(1);
         atlas_height_ff <= EDGE_W'(1);
      end else if (csr_write) begin
         if (csr_paddr[2] == ADDR_WIDTH_REG) begin
            atlas_width_ff <= csr_pwdata[EDGE_W-1:0];
         end else begin
            atlas_height_ff <= csr_pwdata[EDGE_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == ADDR_HEIGHT_REG) ? 32'(atlas_height_ff)
                                                         : 32'(atlas_width_ff);

   sqv_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_src_x       (req_src_x),
      .req_src_y       (req_src_y),
      .req_src_width   (req_src_width),
      .req_src_height  (req_src_height),
      .req_angle       (req_angle),
      .req_colour      (req_colour),
      .req_flags       (req_flags),
      .req_tex_slot    (req_tex_slot),
      .atlas_width     (atlas_width_ff),
      .atlas_height    (atlas_height_ff),
      .q_status        (q_status),
      .push            (push),
      .push_data       (push_data)
   );

   sqv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   sqv_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_tex_u         (rsp_tex_u),
      .rsp_tex_v         (rsp_tex_v),
      .rsp_vertex_colour (rsp_vertex_colour),
      .rsp_vertex_flags  (rsp_vertex_flags),
      .rsp_vertex_slot   (rsp_vertex_slot),
      .rsp_corner        (rsp_corner),
      .rsp_last          (rsp_last)
   );

   `SQV_ASSERT_IMPLIES(a_no_overfill, clock, reset, q_status.full, !push)
   `SQV_ASSERT_IMPLIES(a_last_on_bl, clock, reset, rsp_valid, rsp_last == (rsp_corner == CORNER_BL))
   `SQV_ASSERT_NEXT(a_corner_step, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && rsp_corner == $past(rsp_corner) + 2'd1)

endmodule

FILE: sv/sqv_front.sv
module sqv_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sqv_pkg::POS_W-1:0]   req_rect_x,
   input  logic [sqv_pkg::POS_W-1:0]   req_rect_y,
   input  logic [sqv_pkg::DIM_W-1:0]   req_rect_width,
   input  logic [sqv_pkg::DIM_W-1:0]   req_rect_height,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_x,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_y,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_width,
   input  logic [sqv_pkg::SRC_W-1:0]   req_src_height,
   input  logic [sqv_pkg::ANG_W-1:0]   req_angle,
   input  logic [sqv_pkg::COL_W-1:0]   req_colour,
   input  logic [sqv_pkg::FLG_W-1:0]   req_flags,
   input  logic [sqv_pkg::SLOT_W-1:0]  req_tex_slot,
   input  logic [sqv_pkg::EDGE_W-1:0]  atlas_width,
   input  logic [sqv_pkg::EDGE_W-1:0]  atlas_height,
   input  sqv_pkg::queue_status_type   q_status,
   output logic                        push,
   output sqv_pkg::quad_type           push_data
);
   import sqv_pkg::*;

   typedef struct packed {
      logic signed [POS_W-1:0]  rect_x;
      logic signed [POS_W-1:0]  rect_y;
      logic [DIM_W-1:0]         rect_width;
      logic [DIM_W-1:0]         rect_height;
      logic [ANG_W-1:0]         angle;
      logic [COL_W-1:0]         colour;
      logic [FLG_W-1:0]         flags;
      logic [SLOT_W-1:0]        slot;
      logic [LANES-1:0][EDGE_W-1:0] rem;
      logic [LANES-1:0][FRAC_W-1:0] quo;
      logic [LANES-1:0]         sat;
      logic [15:0]              x_s;
      logic [15:0]              x_c;
      logic [15:0]              x2_s;
      logic [15:0]              x2_c;
      logic [15:0]              t_s;
      logic [15:0]              t_c;
      logic signed [TRIG_W-1:0] sn;
      logic signed [TRIG_W-1:0] cs;
      logic signed [PROD_W-1:0] wc;
      logic signed [PROD_W-1:0] ws;
      logic signed [PROD_W-1:0] hc;
      logic signed [PROD_W-1:0] hs;
   } stage_type;

   stage_type pipe_ff [PIPE_LAST+1];
   stage_type pipe_in [PIPE_LAST+1];
   logic [PIPE_LAST:0] valid_ff, valid_in;
   logic advance;
   logic [EDGE_W-1:0] size_u, size_v;
   logic [LANES-1:0][EDGE_W-1:0] size_l;
   logic [LANES-1:0][15:0] half_l;
   logic [LANES-1:0][EDGE_W-1:0] edge_l;

   function automatic logic [15:0] mul_q14(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] p;
      p = 32'(a) * 32'(b);
      return p[29:14];
   endfunction

   // a zero atlas size counts as one
   assign size_u = (atlas_width == '0) ? EDGE_W'(1) : atlas_width;
   assign size_v = (atlas_height == '0) ? EDGE_W'(1) : atlas_height;
   assign size_l = {size_v, size_v, size_u, size_u};
   assign half_l = {{4'd0, size_v[EDGE_W-1:1]}, {4'd0, size_v[EDGE_W-1:1]},
                    {4'd0, size_u[EDGE_W-1:1]}, {4'd0, size_u[EDGE_W-1:1]}};
   assign edge_l = {{1'b0, req_src_y} + {1'b0, req_src_height}, {1'b0, req_src_y},
                    {1'b0, req_src_x} + {1'b0, req_src_width}, {1'b0, req_src_x}};

   assign advance   = !valid_ff[PIPE_LAST] || !q_status.full;
   assign req_stall = !advance;
   assign valid_in  = {valid_ff[PIPE_LAST-1:0], req_valid};

   always_comb begin
      logic [EDGE_W:0] trial;
      logic signed [TRIG_W-1:0] sr, cr;
      logic signed [TRIG_W-1:0] w_s, h_s;
      pipe_in[0] = '0;
      pipe_in[0].rect_x      = signed'(req_rect_x);
      pipe_in[0].rect_y      = signed'(req_rect_y);
      pipe_in[0].rect_width  = req_rect_width;
      pipe_in[0].rect_height = req_rect_height;
      pipe_in[0].angle       = req_angle;
      pipe_in[0].colour      = req_colour;
      pipe_in[0].flags       = req_flags;
      pipe_in[0].slot        = req_tex_slot;
      pipe_in[0].x_s         = {2'd0, req_angle[13:0]};
      pipe_in[0].x_c         = ONE_Q14 - {2'd0, req_angle[13:0]};
      for (int l = 0; l < LANES; l++) begin
         pipe_in[0].rem[l] = edge_l[l];
         // quotient reaches 1.0 once the edge meets the atlas size
         pipe_in[0].sat[l] = edge_l[l] >= size_l[l];
      end
      for (int i = 1; i <= PIPE_LAST; i++) begin
         pipe_in[i] = pipe_ff[i-1];
         // one restoring division step per stage, rounding bias fed in as low bits
         for (int l = 0; l < LANES; l++) begin
            trial = {pipe_ff[i-1].rem[l], half_l[l][DIV_STEPS-i]};
            if (trial >= {1'b0, size_l[l]}) begin
               pipe_in[i].rem[l] = EDGE_W'(trial - {1'b0, size_l[l]});
               pipe_in[i].quo[l] = {pipe_ff[i-1].quo[l][FRAC_W-2:0], 1'b1};
            end else begin
               pipe_in[i].rem[l] = trial[EDGE_W-1:0];
               pipe_in[i].quo[l] = {pipe_ff[i-1].quo[l][FRAC_W-2:0], 1'b0};
            end
         end
         sr  = signed'({1'b0, pipe_ff[i-1].t_s});
         cr  = signed'({1'b0, pipe_ff[i-1].t_c});
         w_s = signed'({1'b0, pipe_ff[i-1].rect_width});
         h_s = signed'({1'b0, pipe_ff[i-1].rect_height});
         case (i)
            1: begin
               pipe_in[i].x2_s = mul_q14(pipe_ff[i-1].x_s, pipe_ff[i-1].x_s);
               pipe_in[i].x2_c = mul_q14(pipe_ff[i-1].x_c, pipe_ff[i-1].x_c);
            end
            2: begin
               pipe_in[i].t_s = mul_q14(SIN_C, pipe_ff[i-1].x2_s);
               pipe_in[i].t_c = mul_q14(SIN_C, pipe_ff[i-1].x2_c);
            end
            3: begin
               pipe_in[i].t_s = mul_q14(SIN_B - pipe_ff[i-1].t_s, pipe_ff[i-1].x2_s);
               pipe_in[i].t_c = mul_q14(SIN_B - pipe_ff[i-1].t_c, pipe_ff[i-1].x2_c);
            end
            4: begin
               pipe_in[i].t_s = mul_q14(pipe_ff[i-1].x_s, SIN_A - pipe_ff[i-1].t_s);
               pipe_in[i].t_c = mul_q14(pipe_ff[i-1].x_c, SIN_A - pipe_ff[i-1].t_c);
            end
            5: begin
               if (pipe_ff[i-1].angle == '0) begin
                  pipe_in[i].sn = '0;
                  pipe_in[i].cs = signed'({1'b0, ONE_Q14});
               end else begin
                  case (pipe_ff[i-1].angle[ANG_W-1:ANG_W-2])
                     QUAD_0: begin
                        pipe_in[i].sn = sr;
                        pipe_in[i].cs = cr;
                     end
                     QUAD_1: begin
                        pipe_in[i].sn = cr;
                        pipe_in[i].cs = -sr;
                     end
                     QUAD_2: begin
                        pipe_in[i].sn = -sr;
                        pipe_in[i].cs = -cr;
                     end
                     default: begin
                        pipe_in[i].sn = -cr;
                        pipe_in[i].cs = sr;
                     end
                  endcase
               end
            end
            6: begin
               pipe_in[i].wc = PROD_W'(w_s * pipe_ff[i-1].cs);
               pipe_in[i].ws = PROD_W'(w_s * pipe_ff[i-1].sn);
               pipe_in[i].hc = PROD_W'(h_s * pipe_ff[i-1].cs);
               pipe_in[i].hs = PROD_W'(h_s * pipe_ff[i-1].sn);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         for (int i = 0; i <= PIPE_LAST; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign push = valid_ff[PIPE_LAST] && !q_status.full;

   always_comb begin
      stage_type s;
      s = pipe_ff[PIPE_LAST];
      push_data.rect_x      = s.rect_x;
      push_data.rect_y      = s.rect_y;
      push_data.rect_width  = s.rect_width;
      push_data.rect_height = s.rect_height;
      push_data.rotated     = s.angle != '0;
      push_data.wc          = s.wc;
      push_data.ws          = s.ws;
      push_data.hc          = s.hc;
      push_data.hs          = s.hs;
      push_data.u0 = s.sat[0] ? TEX_ONE : {1'b0, s.quo[0]};
      push_data.u1 = s.sat[1] ? TEX_ONE : {1'b0, s.quo[1]};
      push_data.v0 = s.sat[2] ? TEX_ONE : {1'b0, s.quo[2]};
      push_data.v1 = s.sat[3] ? TEX_ONE : {1'b0, s.quo[3]};
      push_data.colour      = s.colour;
      push_data.flags       = s.flags;
      push_data.slot        = s.slot;
   end

endmodule

FILE: sv/sqv_queue.sv
module sqv_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sqv_pkg::quad_type         push_data,
   input  logic                      pop,
   output sqv_pkg::quad_type         head,
   output sqv_pkg::queue_status_type status
);
   import sqv_pkg::*;

   quad_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;

endmodule

FILE: sv/sqv_back.sv
module sqv_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sqv_pkg::quad_type           head,
   input  sqv_pkg::queue_status_type   q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sqv_pkg::POS_W-1:0]   rsp_pos_x,
   output logic [sqv_pkg::POS_W-1:0]   rsp_pos_y,
   output logic [sqv_pkg::TEX_W-1:0]   rsp_tex_u,
   output logic [sqv_pkg::TEX_W-1:0]   rsp_tex_v,
   output logic [sqv_pkg::COL_W-1:0]   rsp_vertex_colour,
   output logic [sqv_pkg::FLG_W-1:0]   rsp_vertex_flags,
   output logic [sqv_pkg::SLOT_W-1:0]  rsp_vertex_slot,
   output logic [1:0]                  rsp_corner,
   output logic                        rsp_last
);
   import sqv_pkg::*;

   corner_type corner_ff, corner_in;
   logic load;
   logic valid_ff, valid_in;
   logic right, bottom;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [TEX_W-1:0] tex_u_ff, tex_v_ff;
   logic [COL_W-1:0] colour_ff;
   logic [FLG_W-1:0] flags_ff;
   logic [SLOT_W-1:0] slot_ff;
   corner_type out_corner_ff;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+2:0] v);
      if (v > POS_MAX) begin
         return POS_W'(POS_MAX);
      end else if (v < POS_MIN) begin
         return POS_W'(POS_MIN);
      end
      return v[POS_W-1:0];
   endfunction

   assign load   = !q_status.empty && (!valid_ff || !rsp_stall);
   assign pop    = load && corner_ff == CORNER_BL;
   assign right  = corner_ff == CORNER_TR || corner_ff == CORNER_BR;
   assign bottom = corner_ff == CORNER_BR || corner_ff == CORNER_BL;
   assign corner_in = load ? corner_type'(corner_ff + 2'd1) : corner_ff;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_comb begin
      logic signed [PROD_W+1:0] ox, oy;
      logic signed [POS_W+17:0] sum_x, sum_y;
      logic signed [POS_W+2:0] px, py;
      ox = (right ? 36'(head.wc) : -36'(head.wc)) - (bottom ? 36'(head.hs) : -36'(head.hs));
      oy = (right ? 36'(head.ws) : -36'(head.ws)) + (bottom ? 36'(head.hc) : -36'(head.hc));
      // position to 2^-19 units, add the offset, round half up back to Q16.4
      sum_x = {{3{head.rect_x[POS_W-1]}}, head.rect_x, 15'd0} + 38'(ox) + 38'sd16384;
      sum_y = {{3{head.rect_y[POS_W-1]}}, head.rect_y, 15'd0} + 38'(oy) + 38'sd16384;
      if (head.rotated) begin
         px = sum_x[POS_W+17:15];
         py = sum_y[POS_W+17:15];
      end else begin
         px = 23'(head.rect_x) + (right ? signed'({7'd0, head.rect_width}) : 23'sd0);
         py = 23'(head.rect_y) + (bottom ? signed'({7'd0, head.rect_height}) : 23'sd0);
      end
      pos_x_in = sat_pos(px);
      pos_y_in = sat_pos(py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= CORNER_TL;
         valid_ff  <= 1'b0;
      end else begin
         corner_ff <= corner_in;
         valid_ff  <= valid_in;
      end
      if (load) begin
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         tex_u_ff      <= right ? head.u1 : head.u0;
         tex_v_ff      <= bottom ? head.v1 : head.v0;
         colour_ff     <= head.colour;
         flags_ff      <= head.flags;
         slot_ff       <= head.slot;
         out_corner_ff <= corner_ff;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_tex_u         = tex_u_ff;
   assign rsp_tex_v         = tex_v_ff;
   assign rsp_vertex_colour = colour_ff;
   assign rsp_vertex_flags  = flags_ff;
   assign rsp_vertex_slot   = slot_ff;
   assign rsp_corner        = out_corner_ff;
   assign rsp_last          = out_corner_ff == CORNER_BL;

endmodule

FILE: tb/sv/sprite_quad_vertex_generator_unit_tb.sv
module sprite_quad_vertex_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sqv_pkg::*;

   localparam logic [2:0] REG_ATLAS_W = 3'h0;
   localparam logic [2:0] REG_ATLAS_H = 3'h4;
   localparam int PIPE_DRAIN = 40;

   typedef struct packed {
      logic signed [POS_W-1:0] rect_x;
      logic signed [POS_W-1:0] rect_y;
      logic [DIM_W-1:0]        rect_width;
      logic [DIM_W-1:0]        rect_height;
      logic [SRC_W-1:0]        src_x;
      logic [SRC_W-1:0]        src_y;
      logic [SRC_W-1:0]        src_width;
      logic [SRC_W-1:0]        src_height;
      logic [ANG_W-1:0]        angle;
      logic [COL_W-1:0]        colour;
      logic [FLG_W-1:0]        flags;
      logic [SLOT_W-1:0]       tex_slot;
   } sprite_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [TEX_W-1:0]  tex_u;
      logic [TEX_W-1:0]  tex_v;
      logic [COL_W-1:0]  colour;
      logic [FLG_W-1:0]  flags;
      logic [SLOT_W-1:0] slot;
      corner_type        corner;
      logic              last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sprite_type sprite_drv = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [POS_W-1:0] rsp_pos_x, rsp_pos_y;
   logic [TEX_W-1:0] rsp_tex_u, rsp_tex_v;
   logic [COL_W-1:0] rsp_vertex_colour;
   logic [FLG_W-1:0] rsp_vertex_flags;
   logic [SLOT_W-1:0] rsp_vertex_slot;
   logic [1:0] rsp_corner;
   logic rsp_last;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic [12:0] atlas_w_model = 13'd1;
   logic [12:0] atlas_h_model = 13'd1;
   vertex_type vertex_queue[$];
   int mismatch_count = 0;
   bit stall_mode = 1'b0;

   sprite_quad_vertex_generator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rect_x(sprite_drv.rect_x), .req_rect_y(sprite_drv.rect_y),
      .req_rect_width(sprite_drv.rect_width), .req_rect_height(sprite_drv.rect_height),
      .req_src_x(sprite_drv.src_x), .req_src_y(sprite_drv.src_y),
      .req_src_width(sprite_drv.src_width), .req_src_height(sprite_drv.src_height),
      .req_angle(sprite_drv.angle), .req_colour(sprite_drv.colour),
      .req_flags(sprite_drv.flags), .req_tex_slot(sprite_drv.tex_slot),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_vertex_colour(rsp_vertex_colour), .rsp_vertex_flags(rsp_vertex_flags),
      .rsp_vertex_slot(rsp_vertex_slot), .rsp_corner(rsp_corner), .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic longint quarter_wave(longint x);
      longint x2, t;
      x2 = (x * x) >>> 14;
      t = (longint'(SIN_C) * x2) >>> 14;
      t = longint'(SIN_B) - t;
      t = (t * x2) >>> 14;
      t = longint'(SIN_A) - t;
      return (x * t) >>> 14;
   endfunction

   function automatic logic [TEX_W-1:0] texel_to_uv(longint edge_t, logic [12:0] size);
      longint sz, q;
      sz = (size == 0) ? 1 : size;
      q = (edge_t * 65536 + sz / 2) / sz;
      return (q > 65536) ? TEX_ONE : q[TEX_W-1:0];
   endfunction

   // Round half toward plus infinity: floor division after the bias.
   function automatic longint round_q15(longint v);
      v = v + 16384;
      return (v >= 0) ? (v >>> 15) : -((-v + 32767) >>> 15);
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(longint v);
      if (v < -524288) v = -524288;
      if (v > 524287) v = 524287;
      return v[POS_W-1:0];
   endfunction

   task automatic predict_quad(sprite_type s);
      longint rx, ry, w, h, sn, cs, sr, cr, dx, dy, px, py;
      logic [13:0] r;
      logic [TEX_W-1:0] u0, u1, v0, v1;
      vertex_type v;
      bit right, bottom;
      rx = s.rect_x; ry = s.rect_y; w = s.rect_width; h = s.rect_height;
      u0 = texel_to_uv(s.src_x, atlas_w_model);
      u1 = texel_to_uv(longint'(s.src_x) + s.src_width, atlas_w_model);
      v0 = texel_to_uv(s.src_y, atlas_h_model);
      v1 = texel_to_uv(longint'(s.src_y) + s.src_height, atlas_h_model);
      sn = 0; cs = 16384;
      if (s.angle != 0) begin
         r = s.angle[13:0];
         sr = quarter_wave(r);
         cr = quarter_wave(16384 - longint'(r));
         case (s.angle[15:14])
            QUAD_0: begin sn = sr; cs = cr; end
            QUAD_1: begin sn = cr; cs = -sr; end
            QUAD_2: begin sn = -sr; cs = -cr; end
            default: begin sn = -cr; cs = sr; end
         endcase
      end
      for (int k = 0; k < 4; k++) begin
         right = (k == 1 || k == 2);
         bottom = (k >= 2);
         if (s.angle == 0) begin
            px = rx + (right ? w : 0);
            py = ry + (bottom ? h : 0);
         end else begin
            dx = right ? w : -w;
            dy = bottom ? h : -h;
            px = round_q15(rx * 32768 + dx * cs - dy * sn);
            py = round_q15(ry * 32768 + dx * sn + dy * cs);
         end
         v.pos_x = clamp_pos(px);
         v.pos_y = clamp_pos(py);
         v.tex_u = right ? u1 : u0;
         v.tex_v = bottom ? v1 : v0;
         v.colour = s.colour;
         v.flags = s.flags;
         v.slot = s.tex_slot;
         v.corner = corner_type'(k);
         v.last = (k == 3);
         vertex_queue.push_back(v);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   // Check each vertex beat against the oldest prediction.
   always @(posedge clock) begin
      vertex_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vertex_queue.size() == 0) begin
            report_mismatch("unexpected vertex", rsp_corner, 0);
         end else begin
            w = vertex_queue.pop_front();
            if (rsp_pos_x !== w.pos_x) report_mismatch("pos_x", rsp_pos_x, w.pos_x);
            if (rsp_pos_y !== w.pos_y) report_mismatch("pos_y", rsp_pos_y, w.pos_y);
            if (rsp_tex_u !== w.tex_u) report_mismatch("tex_u", rsp_tex_u, w.tex_u);
            if (rsp_tex_v !== w.tex_v) report_mismatch("tex_v", rsp_tex_v, w.tex_v);
            if (rsp_vertex_colour !== w.colour)
               report_mismatch("colour", rsp_vertex_colour, w.colour);
            if (rsp_vertex_flags !== w.flags)
               report_mismatch("flags", rsp_vertex_flags, w.flags);
            if (rsp_vertex_slot !== w.slot) report_mismatch("slot", rsp_vertex_slot, w.slot);
            if (rsp_corner !== w.corner) report_mismatch("corner", rsp_corner, w.corner);
            if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
         end
      end
   end

   // Receiver stall pattern: free-running phases, sometimes never stalling.
   always @(posedge clock) begin
      if (stall_mode) rsp_stall <= ($urandom_range(0, 2) == 0);
      else rsp_stall <= 1'b0;
      if ($urandom_range(0, 40) == 0) stall_mode <= ~stall_mode;
   end

   task automatic write_atlas(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == REG_ATLAS_W) atlas_w_model = value[12:0];
      else if (addr == REG_ATLAS_H) atlas_h_model = value[12:0];
   endtask

   task automatic send_sprite(sprite_type s);
      req_valid <= 1'b1;
      sprite_drv <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_quad(s);
   endtask

   task automatic drain_quads();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (vertex_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   function automatic sprite_type random_sprite(bit tight);
      sprite_type s;
      s.rect_x = POS_W'($urandom);
      s.rect_y = POS_W'($urandom);
      s.rect_width = DIM_W'($urandom);
      s.rect_height = DIM_W'($urandom);
      if (tight) begin
         s.rect_x = POS_W'($urandom_range(0, 8000) - 4000);
         s.rect_y = POS_W'($urandom_range(0, 8000) - 4000);
         s.rect_width = DIM_W'($urandom_range(0, 2000));
         s.rect_height = DIM_W'($urandom_range(0, 2000));
      end
      s.src_x = SRC_W'($urandom); s.src_y = SRC_W'($urandom);
      s.src_width = SRC_W'($urandom); s.src_height = SRC_W'($urandom);
      case ($urandom_range(0, 5))
         0: s.angle = 16'h0;
         1: s.angle = {2'($urandom_range(0, 3)), 14'h0};
         default: s.angle = ANG_W'($urandom);
      endcase
      s.colour = $urandom; s.flags = FLG_W'($urandom); s.tex_slot = SLOT_W'($urandom);
      return s;
   endfunction

   sprite_type directed_rows[$];
   vertex_type row_first[$];

   initial begin
      sprite_type s;
      vertex_type tl, want;
      int burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset atlas of one texel: any nonzero edge saturates to 1.0.
      s = '{rect_x: 20'sd100, rect_y: -20'sd50, rect_width: 16'd32, rect_height: 16'd16,
            src_x: 12'd0, src_y: 12'd1, src_width: 12'd1, src_height: 12'd0,
            angle: 16'h0, colour: 32'hDEADBEEF, flags: 16'hA5A5, tex_slot: 5'd7};
      directed_rows.push_back(s);
      want = '{pos_x: 20'd100, pos_y: -20'sd50, tex_u: 17'd0, tex_v: TEX_ONE,
         colour: 32'hDEADBEEF, flags: 16'hA5A5, slot: 5'd7, corner: CORNER_TL, last: 1'b0};
      row_first.push_back(want);
      s = '{rect_x: 20'sh7FFFF, rect_y: 20'sh80000, rect_width: 16'hFFFF,
            rect_height: 16'hFFFF, src_x: 12'hFFF, src_y: 12'hFFF, src_width: 12'hFFF,
            src_height: 12'hFFF, angle: 16'h0, colour: 32'hFFFFFFFF, flags: 16'hFFFF,
            tex_slot: 5'd31};
      directed_rows.push_back(s);
      want = '{pos_x: 20'h7FFFF, pos_y: 20'h80000, tex_u: TEX_ONE,
         tex_v: TEX_ONE, colour: 32'hFFFFFFFF, flags: 16'hFFFF, slot: 5'd31,
         corner: CORNER_TL, last: 1'b0};
      row_first.push_back(want);
      foreach (directed_rows[i]) begin
         send_sprite(directed_rows[i]);
         tl = vertex_queue[vertex_queue.size() - 4];
         if (tl !== row_first[i])
            report_mismatch("directed top-left", longint'(tl), longint'(row_first[i]));
      end
      drain_quads();

      // Zero sizes act as one.
      write_atlas(REG_ATLAS_W, 32'h0);
      write_atlas(REG_ATLAS_H, 32'h0);
      for (int a = 0; a < 8; a++) begin
         s = random_sprite(1'b1);
         s.angle = 16'(a * 16'h2000 + (a[0] ? 16'h1 : 16'h0));
         send_sprite(s);
      end
      drain_quads();

      write_atlas(REG_ATLAS_W, 32'd4096);
      write_atlas(REG_ATLAS_H, 32'd4096);
      s = random_sprite(1'b0);
      s.rect_x = 20'sh80000; s.rect_y = 20'sh7FFFF; s.angle = 16'hFFFF;
      send_sprite(s);
      s.rect_width = '0; s.rect_height = '0; s.angle = 16'h4000;
      send_sprite(s);
      drain_quads();

      // Atlas wider than the source range, odd and random sizes, each followed by randomised bursts.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_atlas(REG_ATLAS_W, 32'h1FFF); write_atlas(REG_ATLAS_H, 32'd3); end
            1: begin write_atlas(REG_ATLAS_W, 32'd1); write_atlas(REG_ATLAS_H, 32'h1FFF); end
            2: begin
               write_atlas(REG_ATLAS_W, $urandom_range(1, 4096));
               write_atlas(REG_ATLAS_H, $urandom_range(1, 4096));
            end
            default: begin
               write_atlas(REG_ATLAS_W, $urandom);
               write_atlas(REG_ATLAS_H, $urandom);
            end
         endcase
         for (int n = 0; n < 24;) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && n < 24; b++, n++)
               send_sprite(random_sprite($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 2) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         drain_quads();
      end

      if (mismatch_count == 0 && vertex_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
